// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file of the allocator.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising edge, ignore cycles in reset.
`define BFPA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising edge, reset cycles included.
`define BFPA_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/bfpa_pkg.sv =====
// Package of the best-fit pool allocator: widths, codes, entry types.
// No dependencies.
package bfpa_pkg;

  localparam int ADDR_W     = 32;
  localparam int TL_W       = 64;
  localparam int DLY_W      = 8;
  localparam int FREED_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [ADDR_W-1:0]  POOL_SIZE_RST    = 32'hFFFF_FFFF;
  localparam logic [DLY_W-1:0]   RETIRE_DELAY_RST = 8'd12;
  localparam logic [FREED_W-1:0] FREED_MAX        = 7'd127;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_DISCARD = 2'd1,
    MODE_ADVANCE = 2'd2,
    MODE_NOP     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FIT  = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_UNKNOWN = 2'd3
  } status_t;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_POOL_SIZE    = 2'd0;
  localparam cfg_idx_t CFG_RETIRE_DELAY = 2'd1;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] len;
    logic              free;
  } blk_t;

  typedef struct packed {
    logic [ADDR_W-1:0] offset;
    logic [TL_W-1:0]   tl;
  } pend_t;

  typedef struct packed {
    logic shift;
    logic kill;
  } ring_ctl_t;

  typedef enum logic [4:0] {
    FSM_FORMAT,
    FSM_IDLE,
    FSM_AL_SCAN,
    FSM_AL_DEC,
    FSM_AL_COMMIT,
    FSM_DC_FIND,
    FSM_DC_DEC,
    FSM_DC_PEND,
    FSM_DC_PDEC,
    FSM_DC_INS,
    FSM_AV_PICK,
    FSM_AV_PDEC,
    FSM_AV_CUR,
    FSM_AV_CDEC,
    FSM_AV_NBR,
    FSM_AV_MERGE,
    FSM_RESP
  } fsm_t;

endpackage

// ===== hw/rtl/bfpa_ifs.sv =====
// Channel interfaces of the allocator: request, result and register write.
// Depends on bfpa_pkg.
interface bfpa_in_if;
  import bfpa_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [ADDR_W-1:0] req_bytes;
  logic [ADDR_W-1:0] block_offset;
  logic [TL_W-1:0]   timeline;
  modport source (output valid, mode, req_bytes, block_offset, timeline, input ready);
  modport sink   (input valid, mode, req_bytes, block_offset, timeline, output ready);
endinterface

interface bfpa_out_if;
  import bfpa_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [ADDR_W-1:0]  granted_offset;
  logic [FREED_W-1:0] freed_count;
  modport source (output valid, status, granted_offset, freed_count, input ready);
  modport sink   (input valid, status, granted_offset, freed_count, output ready);
endinterface

interface bfpa_cfg_if;
  import bfpa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/bfpa_cell.sv =====
// One cell of a rotating table: a valid bit and one entry.
// No dependencies.
module bfpa_cell #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         shift,
  input  logic         kill,
  input  logic         prev_v,
  input  logic [W-1:0] prev_d,
  output logic         v_r,
  output logic [W-1:0] d_r
);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (shift) begin
      v_r <= prev_v & ~kill;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      d_r <= prev_d;
    end
  end

endmodule

// ===== hw/rtl/bfpa_ring.sv =====
// Chain of table cells; the head is fed by the controller, the tail is shown.
// Depends on bfpa_pkg and bfpa_cell.
module bfpa_ring #(
  parameter int DEPTH = 64,
  parameter int W     = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bfpa_pkg::ring_ctl_t  ctl,
  input  logic                 head_v,
  input  logic [W-1:0]         head_d,
  output logic                 tail_v,
  output logic [W-1:0]         tail_d
);
  import bfpa_pkg::*;

  logic [DEPTH-1:0] v;
  logic [W-1:0]     d [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      bfpa_cell #(.W(W)) u_cell (
        .clk(clk), .rst_n(rst_n), .shift(ctl.shift), .kill(1'b0),
        .prev_v(head_v), .prev_d(head_d), .v_r(v[i]), .d_r(d[i])
      );
    end else begin : g_body
      // drop everything in flight on a kill, the head entry survives
      bfpa_cell #(.W(W)) u_cell (
        .clk(clk), .rst_n(rst_n), .shift(ctl.shift), .kill(ctl.kill),
        .prev_v(v[i-1]), .prev_d(d[i-1]), .v_r(v[i]), .d_r(d[i])
      );
    end
  end

  assign tail_v = v[DEPTH-1];
  assign tail_d = d[DEPTH-1];

endmodule

// ===== hw/rtl/best_fit_pool_allocator.sv =====
// Best-fit pool allocator with coalescing and delayed retirement.
// Depends on bfpa_pkg, bfpa_ifs, bfpa_ring (and through it bfpa_cell).
//
// Use: one transaction on in_bus carries a command (allocate, discard, advance,
// no-op); exactly one transaction on out_bus returns its status, granted offset
// and freed count. cfg_bus writes pool_size (reformats the pool) or
// retire_delay; it is taken only while the block is idle.
// The block table and the pending queue are rings of cells. Every pass
// rotates one ring by its full depth (MAX_BLOCKS or MAX_PENDING entries), so
// each entry is examined at the ring tail and rewritten at the head.
// One command is worked at a time; the ring rotation sets the rate. A new command
// is accepted while a stalled result waits on out_bus; its result is then held.
// Reset: synchronous, active low; the format state after reset leaves one
// free block over the pool and an empty queue; a pool_size write does the same.
module best_fit_pool_allocator #(
  parameter int MAX_BLOCKS  = 64,
  parameter int MAX_PENDING = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  bfpa_in_if.sink    in_bus,
  bfpa_out_if.source out_bus,
  bfpa_cfg_if.sink   cfg_bus
);
  import bfpa_pkg::*;

  localparam int MAXD = (MAX_BLOCKS > MAX_PENDING) ? MAX_BLOCKS : MAX_PENDING;
  localparam int CW   = $clog2(MAXD);
  localparam logic [CW-1:0] BLK_LAST  = CW'(MAX_BLOCKS - 1);
  localparam logic [CW-1:0] PEND_LAST = CW'(MAX_PENDING - 1);
  localparam int BW = $bits(blk_t);
  localparam int PW = $bits(pend_t);

  // controller state
  fsm_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  // command
  logic [ADDR_W-1:0] req_r, req_nxt;
  logic [ADDR_W-1:0] off_r, off_nxt;
  logic [TL_W-1:0]   tl_r, tl_nxt;
  // registers
  logic [ADDR_W-1:0] pool_r, pool_nxt;
  logic [DLY_W-1:0]  dly_r, dly_nxt;
  // scan results
  logic found_r, found_nxt;
  logic spare_r, spare_nxt;
  logic dup_r, dup_nxt;
  logic used_r, used_nxt;
  logic [ADDR_W-1:0] best_start_r, best_start_nxt;
  logic [ADDR_W-1:0] best_len_r, best_len_nxt;
  logic pick_r, pick_nxt;
  logic [ADDR_W-1:0] pick_off_r, pick_off_nxt;
  logic kill_r, kill_nxt;
  logic [ADDR_W:0]   cur_end_r, cur_end_nxt;
  logic pred_r, pred_nxt;
  logic succ_r, succ_nxt;
  logic [ADDR_W-1:0] madd_r, madd_nxt;
  logic [FREED_W-1:0] nfreed_r, nfreed_nxt;
  // result staging and output register
  status_t res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]  res_granted_r, res_granted_nxt;
  logic [FREED_W-1:0] res_freed_r, res_freed_nxt;
  logic out_v_r, out_v_nxt;
  status_t out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]  out_granted_r, out_granted_nxt;
  logic [FREED_W-1:0] out_freed_r, out_freed_nxt;

  // ring ports
  ring_ctl_t blk_ctl, pend_ctl;
  logic  blk_head_v, blk_tail_v, pend_head_v, pend_tail_v;
  blk_t  blk_head, blk_tail;
  pend_t pend_head, pend_tail;
  logic [BW-1:0] blk_tail_bits;
  logic [PW-1:0] pend_tail_bits;

  bfpa_ring #(.DEPTH(MAX_BLOCKS), .W(BW)) u_blk_ring (
    .clk(clk), .rst_n(rst_n), .ctl(blk_ctl),
    .head_v(blk_head_v), .head_d(blk_head),
    .tail_v(blk_tail_v), .tail_d(blk_tail_bits)
  );

  bfpa_ring #(.DEPTH(MAX_PENDING), .W(PW)) u_pend_ring (
    .clk(clk), .rst_n(rst_n), .ctl(pend_ctl),
    .head_v(pend_head_v), .head_d(pend_head),
    .tail_v(pend_tail_v), .tail_d(pend_tail_bits)
  );

  assign blk_tail  = blk_t'(blk_tail_bits);
  assign pend_tail = pend_t'(pend_tail_bits);

  // per-entry arithmetic at the ring tails
  logic [ADDR_W:0] blk_end;
  logic            blk_better;
  logic            pend_rdy;
  logic            blk_last, pend_last;

  assign blk_end = {1'b0, blk_tail.start} + {1'b0, blk_tail.len};
  assign blk_better = !found_r || (blk_tail.len < best_len_r) ||
                      ((blk_tail.len == best_len_r) && (blk_tail.start < best_start_r));
  // ready when finished >= timeline + delay, sum taken without wrap
  assign pend_rdy = ({1'b0, tl_r} >= ({1'b0, pend_tail.tl} + (TL_W + 1)'(dly_r)));
  assign blk_last  = (cnt_r == BLK_LAST);
  assign pend_last = (cnt_r == PEND_LAST);

  assign in_bus.ready   = (st_r == FSM_IDLE) && !cfg_bus.valid;
  assign cfg_bus.ready  = (st_r == FSM_IDLE);
  assign out_bus.valid          = out_v_r;
  assign out_bus.status         = out_status_r;
  assign out_bus.granted_offset = out_granted_r;
  assign out_bus.freed_count    = out_freed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= FSM_FORMAT;
      out_v_r <= 1'b0;
      pool_r  <= POOL_SIZE_RST;
      dly_r   <= RETIRE_DELAY_RST;
      cnt_r   <= '0;
    end else begin
      st_r    <= st_nxt;
      out_v_r <= out_v_nxt;
      pool_r  <= pool_nxt;
      dly_r   <= dly_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    off_r         <= off_nxt;
    tl_r          <= tl_nxt;
    found_r       <= found_nxt;
    spare_r       <= spare_nxt;
    dup_r         <= dup_nxt;
    used_r        <= used_nxt;
    best_start_r  <= best_start_nxt;
    best_len_r    <= best_len_nxt;
    pick_r        <= pick_nxt;
    pick_off_r    <= pick_off_nxt;
    kill_r        <= kill_nxt;
    cur_end_r     <= cur_end_nxt;
    pred_r        <= pred_nxt;
    succ_r        <= succ_nxt;
    madd_r        <= madd_nxt;
    nfreed_r      <= nfreed_nxt;
    res_status_r  <= res_status_nxt;
    res_granted_r <= res_granted_nxt;
    res_freed_r   <= res_freed_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_freed_r   <= out_freed_nxt;
  end

  always_comb begin
    st_nxt          = st_r;
    cnt_nxt         = cnt_r;
    req_nxt         = req_r;
    off_nxt         = off_r;
    tl_nxt          = tl_r;
    pool_nxt        = pool_r;
    dly_nxt         = dly_r;
    found_nxt       = found_r;
    spare_nxt       = spare_r;
    dup_nxt         = dup_r;
    used_nxt        = used_r;
    best_start_nxt  = best_start_r;
    best_len_nxt    = best_len_r;
    pick_nxt        = pick_r;
    pick_off_nxt    = pick_off_r;
    kill_nxt        = kill_r;
    cur_end_nxt     = cur_end_r;
    pred_nxt        = pred_r;
    succ_nxt        = succ_r;
    madd_nxt        = madd_r;
    nfreed_nxt      = nfreed_r;
    res_status_nxt  = res_status_r;
    res_granted_nxt = res_granted_r;
    res_freed_nxt   = res_freed_r;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    out_freed_nxt   = out_freed_r;
    out_v_nxt       = out_v_r && !out_bus.ready;

    // a shifted ring rotates its entries unchanged unless the state says otherwise
    blk_ctl     = '{shift: 1'b0, kill: 1'b0};
    pend_ctl    = '{shift: 1'b0, kill: 1'b0};
    blk_head_v  = blk_tail_v;
    blk_head    = blk_tail;
    pend_head_v = pend_tail_v;
    pend_head   = pend_tail;

    unique case (st_r)
      FSM_FORMAT: begin
        // one free block over the pool, queue emptied
        blk_ctl     = '{shift: 1'b1, kill: 1'b1};
        pend_ctl    = '{shift: 1'b1, kill: 1'b1};
        blk_head_v  = 1'b1;
        blk_head    = '{start: '0, len: pool_r, free: 1'b1};
        pend_head_v = 1'b0;
        cnt_nxt     = '0;
        st_nxt      = FSM_IDLE;
      end

      FSM_IDLE: begin
        cnt_nxt   = '0;
        found_nxt = 1'b0;
        spare_nxt = 1'b0;
        dup_nxt   = 1'b0;
        used_nxt  = 1'b0;
        res_granted_nxt = '0;
        res_freed_nxt   = '0;
        if (cfg_bus.valid) begin
          if (cfg_bus.index == CFG_POOL_SIZE) begin
            pool_nxt = cfg_bus.data;
            st_nxt   = FSM_FORMAT;
          end else if (cfg_bus.index == CFG_RETIRE_DELAY) begin
            dly_nxt = cfg_bus.data[DLY_W-1:0];
          end
        end else if (in_bus.valid) begin
          req_nxt = in_bus.req_bytes;
          off_nxt = in_bus.block_offset;
          tl_nxt  = in_bus.timeline;
          unique case (mode_t'(in_bus.mode))
            MODE_ALLOC: begin
              if (in_bus.req_bytes == '0) begin
                res_status_nxt = STAT_NO_FIT;
                st_nxt         = FSM_RESP;
              end else begin
                st_nxt = FSM_AL_SCAN;
              end
            end
            MODE_DISCARD: st_nxt = FSM_DC_FIND;
            MODE_ADVANCE: begin
              pick_nxt   = 1'b0;
              kill_nxt   = 1'b0;
              nfreed_nxt = '0;
              st_nxt     = FSM_AV_PICK;
            end
            default: begin
              res_status_nxt = STAT_OK;
              st_nxt         = FSM_RESP;
            end
          endcase
        end
      end

      // allocate: find the smallest fitting free block, note a spare slot
      FSM_AL_SCAN: begin
        blk_ctl.shift = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (!blk_tail_v) begin
          spare_nxt = 1'b1;
        end else if (blk_tail.free && (blk_tail.len >= req_r) && blk_better) begin
          found_nxt      = 1'b1;
          best_start_nxt = blk_tail.start;
          best_len_nxt   = blk_tail.len;
        end
        if (blk_last) begin
          cnt_nxt = '0;
          st_nxt  = FSM_AL_DEC;
        end
      end

      FSM_AL_DEC: begin
        if (!found_r) begin
          res_status_nxt = STAT_NO_FIT;
          st_nxt         = FSM_RESP;
        end else if ((best_len_r != req_r) && !spare_r) begin
          res_status_nxt = STAT_FULL;
          st_nxt         = FSM_RESP;
        end else begin
          st_nxt = FSM_AL_COMMIT;
        end
      end

      // allocate: shrink the chosen block, drop the remainder in a spare slot
      FSM_AL_COMMIT: begin
        blk_ctl.shift = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (blk_tail_v && blk_tail.free && (blk_tail.start == best_start_r)) begin
          blk_head.len  = req_r;
          blk_head.free = 1'b0;
        end else if (!blk_tail_v && (best_len_r != req_r) && !used_r) begin
          used_nxt   = 1'b1;
          blk_head_v = 1'b1;
          blk_head   = '{start: best_start_r + req_r, len: best_len_r - req_r, free: 1'b1};
        end
        if (blk_last) begin
          cnt_nxt         = '0;
          res_status_nxt  = STAT_OK;
          res_granted_nxt = best_start_r;
          st_nxt          = FSM_RESP;
        end
      end

      // discard: the offset must start an allocated block
      FSM_DC_FIND: begin
        blk_ctl.shift = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (blk_tail_v && !blk_tail.free && (blk_tail.start == off_r)) begin
          found_nxt = 1'b1;
        end
        if (blk_last) begin
          cnt_nxt = '0;
          st_nxt  = FSM_DC_DEC;
        end
      end

      FSM_DC_DEC: begin
        if (!found_r) begin
          res_status_nxt = STAT_UNKNOWN;
          st_nxt         = FSM_RESP;
        end else begin
          st_nxt = FSM_DC_PEND;
        end
      end

      FSM_DC_PEND: begin
        pend_ctl.shift = 1'b1;
        cnt_nxt        = cnt_r + 1'b1;
        if (pend_tail_v) begin
          if (pend_tail.offset == off_r) begin
            dup_nxt = 1'b1;
          end
        end else begin
          spare_nxt = 1'b1;
        end
        if (pend_last) begin
          cnt_nxt = '0;
          st_nxt  = FSM_DC_PDEC;
        end
      end

      FSM_DC_PDEC: begin
        if (dup_r) begin
          res_status_nxt = STAT_OK;
          st_nxt         = FSM_RESP;
        end else if (!spare_r) begin
          res_status_nxt = STAT_FULL;
          st_nxt         = FSM_RESP;
        end else begin
          st_nxt = FSM_DC_INS;
        end
      end

      FSM_DC_INS: begin
        pend_ctl.shift = 1'b1;
        cnt_nxt        = cnt_r + 1'b1;
        if (!pend_tail_v && !used_r) begin
          used_nxt    = 1'b1;
          pend_head_v = 1'b1;
          pend_head   = '{offset: off_r, tl: tl_r};
        end
        if (pend_last) begin
          cnt_nxt        = '0;
          res_status_nxt = STAT_OK;
          st_nxt         = FSM_RESP;
        end
      end

      // advance: drop the last pick, find the lowest ready offset
      FSM_AV_PICK: begin
        pend_ctl.shift = 1'b1;
        cnt_nxt        = cnt_r + 1'b1;
        if (pend_tail_v && kill_r && (pend_tail.offset == off_r)) begin
          pend_head_v = 1'b0;
        end else if (pend_tail_v && pend_rdy &&
                     (!pick_r || (pend_tail.offset < pick_off_r))) begin
          pick_nxt     = 1'b1;
          pick_off_nxt = pend_tail.offset;
        end
        if (pend_last) begin
          cnt_nxt = '0;
          st_nxt  = FSM_AV_PDEC;
        end
      end

      FSM_AV_PDEC: begin
        if (!pick_r) begin
          res_status_nxt = STAT_OK;
          res_freed_nxt  = nfreed_r;
          st_nxt         = FSM_RESP;
        end else begin
          off_nxt   = pick_off_r;
          kill_nxt  = 1'b1;
          found_nxt = 1'b0;
          st_nxt    = FSM_AV_CUR;
        end
      end

      FSM_AV_CUR: begin
        blk_ctl.shift = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (blk_tail_v && !blk_tail.free && (blk_tail.start == off_r)) begin
          found_nxt   = 1'b1;
          cur_end_nxt = blk_end;
          madd_nxt    = blk_tail.len;
        end
        if (blk_last) begin
          cnt_nxt = '0;
          st_nxt  = FSM_AV_CDEC;
        end
      end

      FSM_AV_CDEC: begin
        pick_nxt = 1'b0;
        pred_nxt = 1'b0;
        succ_nxt = 1'b0;
        // a queued block that is no longer allocated is dropped silently
        st_nxt   = found_r ? FSM_AV_NBR : FSM_AV_PICK;
      end

      // advance: locate free neighbors, fold the successor length in
      FSM_AV_NBR: begin
        blk_ctl.shift = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (blk_tail_v && blk_tail.free) begin
          if ((off_r != '0) && (blk_end == {1'b0, off_r})) begin
            pred_nxt = 1'b1;
          end
          if ({1'b0, blk_tail.start} == cur_end_r) begin
            succ_nxt = 1'b1;
            madd_nxt = madd_r + blk_tail.len;
          end
        end
        if (blk_last) begin
          cnt_nxt = '0;
          st_nxt  = FSM_AV_MERGE;
        end
      end

      FSM_AV_MERGE: begin
        blk_ctl.shift = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (blk_tail_v) begin
          if (blk_tail.free && pred_r && (off_r != '0) && (blk_end == {1'b0, off_r})) begin
            blk_head.len = blk_tail.len + madd_r;
          end else if (!blk_tail.free && (blk_tail.start == off_r)) begin
            if (pred_r) begin
              blk_head_v = 1'b0;
            end else begin
              blk_head.free = 1'b1;
              blk_head.len  = madd_r;
            end
          end else if (blk_tail.free && succ_r &&
                       ({1'b0, blk_tail.start} == cur_end_r)) begin
            blk_head_v = 1'b0;
          end
        end
        if (blk_last) begin
          cnt_nxt = '0;
          if (nfreed_r != FREED_MAX) begin
            nfreed_nxt = nfreed_r + 1'b1;
          end
          st_nxt = FSM_AV_PICK;
        end
      end

      FSM_RESP: begin
        // hold until the output register is free
        if (!out_v_r || out_bus.ready) begin
          out_v_nxt       = 1'b1;
          out_status_nxt  = res_status_r;
          out_granted_nxt = res_granted_r;
          out_freed_nxt   = res_freed_r;
          st_nxt          = FSM_IDLE;
        end
      end

      default: st_nxt = FSM_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/bfpa_checker.sv =====
// Port-level checks of the allocator, bound to the top level.
// Depends on bfpa_pkg, assert_macros.svh and best_fit_pool_allocator.
`include "assert_macros.svh"

module bfpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_granted,
  input logic [6:0]  out_freed
);
  import bfpa_pkg::*;

  `BFPA_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_status), "result dropped or changed while stalled")
  `BFPA_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready, "second transaction taken while busy")
  `BFPA_ASSERT(a_grant_ok, clk, rst_n, out_valid && (out_granted != '0) |-> out_status == STAT_OK, "grant with error status")
  `BFPA_ASSERT(a_freed_ok, clk, rst_n, out_valid && (out_freed != '0) |-> out_status == STAT_OK, "freed count with error status")
  `BFPA_ASSERT_NR(a_reset_quiet, clk, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind best_fit_pool_allocator bfpa_checker u_bfpa_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_bus.valid),
  .in_ready(in_bus.ready),
  .out_valid(out_bus.valid),
  .out_ready(out_bus.ready),
  .out_status(out_bus.status),
  .out_granted(out_bus.granted_offset),
  .out_freed(out_bus.freed_count)
);
